/* sv/nbt_tok_pkg.sv */
// shared types and constants for the tag stream tokenizer
// no dependencies
`default_nettype none
package nbt_tok_pkg;

	localparam int MAX_DEPTH = 16;
	localparam int SP_W      = $clog2(MAX_DEPTH + 1);
	localparam int IDX_W     = $clog2(MAX_DEPTH);
	localparam int BL_W      = 35;

	typedef enum logic [3:0] {
		PH_ROOT_ID   = 4'd0,
		PH_NAME_HI   = 4'd1,
		PH_NAME_LO   = 4'd2,
		PH_NAME      = 4'd3,
		PH_TAG_ID    = 4'd4,
		PH_LIST_TYPE = 4'd5,
		PH_COUNT     = 4'd6,
		PH_STRLEN_HI = 4'd7,
		PH_STRLEN_LO = 4'd8,
		PH_PAYLOAD   = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_EXEC,
		SEQ_POP,
		SEQ_BEGIN
	} seq_t;

	typedef enum logic [2:0] {
		K_TAG_ID   = 3'd0,
		K_NAME_LEN = 3'd1,
		K_NAME     = 3'd2,
		K_LIST_TYP = 3'd3,
		K_COUNT    = 3'd4,
		K_PAYLOAD  = 3'd5,
		K_END      = 3'd6,
		K_IGNORED  = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_RUN       = 3'd0,
		ST_BAD_ID    = 3'd1,
		ST_ROOT      = 3'd2,
		ST_END_LIST  = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_TRUNC     = 3'd5,
		ST_DONE      = 3'd6
	} status_t;

	localparam logic [3:0] T_END      = 4'd0;
	localparam logic [3:0] T_BYTE     = 4'd1;
	localparam logic [3:0] T_SHORT    = 4'd2;
	localparam logic [3:0] T_INT      = 4'd3;
	localparam logic [3:0] T_LONG     = 4'd4;
	localparam logic [3:0] T_FLOAT    = 4'd5;
	localparam logic [3:0] T_DOUBLE   = 4'd6;
	localparam logic [3:0] T_BYTE_ARR = 4'd7;
	localparam logic [3:0] T_STRING   = 4'd8;
	localparam logic [3:0] T_LIST     = 4'd9;
	localparam logic [3:0] T_COMPOUND = 4'd10;
	localparam logic [3:0] T_INT_ARR  = 4'd11;
	localparam logic [3:0] T_LONG_ARR = 4'd12;
	localparam logic [7:0] MAX_ID     = 8'd12;

	typedef struct packed {
		logic        is_list;
		logic [3:0]  elem_type;
		logic [31:0] remaining;
	} frame_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		frame_t           data;
	} stack_wr_t;

endpackage
`default_nettype wire

/* sv/nbt_tok_stack.sv */
// frame stack of open compounds and lists, one write and one registered read port
// depends on nbt_tok_pkg
`default_nettype none
module nbt_tok_stack (
	input  wire                           clk,
	input  nbt_tok_pkg::stack_wr_t        wr,
	input  wire [nbt_tok_pkg::IDX_W-1:0]  rd_idx,
	output nbt_tok_pkg::frame_t           rd_data
);
	import nbt_tok_pkg::*;

	frame_t frames_q [MAX_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			frames_q[wr.idx] <= wr.data;
		end
	end

	// rd_idx is the top frame after this edge; a write to it is passed straight through
	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == rd_idx) begin
			rd_data <= wr.data;
		end else begin
			rd_data <= frames_q[rd_idx];
		end
	end

endmodule
`default_nettype wire

/* sv/nbt_stream_tokenizer_unit.sv */
// byte tokenizer for a binary tag stream: top level with sequencer and output register
// depends on nbt_tok_pkg and nbt_tok_stack
// an item is accepted, then decoded; one that completes a value adds a pop loop that closes
// one exhausted list per cycle, then a final check, and a begin state to start a list element
// input is not ready while an item is in work or the output register is full and stalled
// async reset clears sequencer, phase, counters, stack pointer and status; stack frames unset
`default_nettype none
module nbt_stream_tokenizer_unit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,  // [7:0] in_byte
	input  wire        s_tuser,  // [0] stream_end
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [31:0] m_tdata, // [2:0] byte_kind, [6:3] tag_type, [11:7] nest_depth,
	                             // [19:12] byte_value, [24:20] closed_count,
	                             // [25] parse_done, [28:26] error_code, rest zero
	output logic       m_tlast   // last_of_field
);
	import nbt_tok_pkg::*;

	seq_t             seq_q, seq_n;
	phase_t           phase_q, phase_n;
	logic [3:0]       ctype_q, ctype_n;
	logic [BL_W-1:0]  bl_q, bl_n;
	logic [31:0]      ael_q, ael_n;
	logic [SP_W-1:0]  sp_q, sp_n;
	status_t          status_q, status_n;
	logic [7:0]       byte_q;
	logic             end_q;
	kind_t            kind_q, kind_n;
	logic [3:0]       ttype_q, ttype_n;
	logic             last_q, last_n;
	logic [4:0]       closed_q, closed_n;
	logic             finish;
	logic             out_load;
	logic [31:0]      out_data;

	stack_wr_t        wr;
	frame_t           top;
	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] rd_idx;
	logic             bv_go;
	logic [3:0]       bv_type;
	logic [BL_W-1:0]  bl_dec;
	logic [31:0]      cnt_n;
	logic [31:0]      n_elem;
	logic             take;

	assign top_idx = IDX_W'(sp_q - SP_W'(1));
	assign rd_idx  = IDX_W'(sp_n - SP_W'(1));

	nbt_tok_stack u_stack (
		.clk     (clk),
		.wr      (wr),
		.rd_idx  (rd_idx),
		.rd_data (top)
	);

	assign s_tready = (seq_q == SEQ_IDLE) && (!m_tvalid || m_tready);
	assign take     = s_tvalid && s_tready;
	assign bl_dec   = (bl_q != '0) ? bl_q - BL_W'(1) : bl_q;
	assign cnt_n    = {ael_q[23:0], byte_q};
	assign n_elem   = cnt_n[31] ? 32'd0 : cnt_n;

	always_comb begin
		seq_n    = seq_q;
		phase_n  = phase_q;
		ctype_n  = ctype_q;
		bl_n     = bl_q;
		ael_n    = ael_q;
		sp_n     = sp_q;
		status_n = status_q;
		kind_n   = kind_q;
		ttype_n  = ttype_q;
		last_n   = last_q;
		closed_n = closed_q;
		finish   = 1'b0;
		bv_go    = 1'b0;
		bv_type  = ctype_q;
		wr.en    = 1'b0;
		wr.idx   = top_idx;
		wr.data  = top;

		case (seq_q)
			SEQ_IDLE: begin
				if (take) begin
					seq_n = SEQ_EXEC;
				end
			end
			SEQ_EXEC: begin
				kind_n   = K_IGNORED;
				ttype_n  = 4'd0;
				last_n   = 1'b0;
				closed_n = 5'd0;
				finish   = 1'b1;
				if (end_q) begin
					if (status_q == ST_RUN) begin
						status_n = ST_TRUNC;
					end
				end else if (status_q == ST_RUN) begin
					ttype_n = ctype_q;
					case (phase_q)
						PH_ROOT_ID: begin
							kind_n = K_TAG_ID;
							if (byte_q == 8'(T_COMPOUND)) begin
								ctype_n = T_COMPOUND;
								ttype_n = T_COMPOUND;
								phase_n = PH_NAME_HI;
							end else if (byte_q > MAX_ID) begin
								ttype_n  = 4'd0;
								status_n = ST_BAD_ID;
							end else begin
								ttype_n  = byte_q[3:0];
								status_n = ST_ROOT;
							end
						end
						PH_TAG_ID: begin
							if (byte_q > MAX_ID) begin
								kind_n   = K_TAG_ID;
								ttype_n  = 4'd0;
								status_n = ST_BAD_ID;
							end else if (byte_q == 8'(T_END)) begin
								kind_n   = K_END;
								ttype_n  = 4'd0;
								closed_n = 5'd1;
								if (sp_q != '0) begin
									sp_n = sp_q - SP_W'(1);
								end
								if (sp_n == '0) begin
									status_n = ST_DONE;
								end else begin
									finish = 1'b0;
									seq_n  = SEQ_POP;
								end
							end else begin
								kind_n  = K_TAG_ID;
								ttype_n = byte_q[3:0];
								ctype_n = byte_q[3:0];
								phase_n = PH_NAME_HI;
							end
						end
						PH_NAME_HI: begin
							kind_n  = K_NAME_LEN;
							bl_n    = BL_W'(byte_q);
							phase_n = PH_NAME_LO;
						end
						PH_NAME_LO: begin
							kind_n = K_NAME_LEN;
							last_n = 1'b1;
							bl_n   = BL_W'({bl_q[7:0], byte_q});
							if (bl_n == '0) begin
								bv_go = 1'b1;
							end else begin
								phase_n = PH_NAME;
							end
						end
						PH_NAME: begin
							kind_n = K_NAME;
							bl_n   = bl_dec;
							if (bl_dec == '0) begin
								last_n = 1'b1;
								bv_go  = 1'b1;
							end
						end
						PH_LIST_TYPE: begin
							kind_n = K_LIST_TYP;
							if (byte_q > MAX_ID) begin
								status_n = ST_BAD_ID;
							end else begin
								wr.en             = 1'b1;
								wr.data.elem_type = byte_q[3:0];
								bl_n              = BL_W'(4);
								ael_n             = 32'd0;
								phase_n           = PH_COUNT;
							end
						end
						PH_COUNT: begin
							kind_n = K_COUNT;
							ael_n  = cnt_n;
							bl_n   = bl_dec;
							if (bl_dec == '0) begin
								last_n = 1'b1;
								if (ctype_q == T_LIST) begin
									wr.en             = 1'b1;
									wr.data.remaining = n_elem;
									finish            = 1'b0;
									seq_n             = SEQ_POP;
								end else begin
									case (ctype_q)
										T_BYTE_ARR: bl_n = BL_W'(n_elem);
										T_INT_ARR:  bl_n = BL_W'(n_elem) << 2;
										default:    bl_n = BL_W'(n_elem) << 3;
									endcase
									if (n_elem == 32'd0) begin
										finish = 1'b0;
										seq_n  = SEQ_POP;
									end else begin
										phase_n = PH_PAYLOAD;
									end
								end
							end
						end
						PH_STRLEN_HI: begin
							kind_n  = K_COUNT;
							bl_n    = BL_W'(byte_q);
							phase_n = PH_STRLEN_LO;
						end
						PH_STRLEN_LO: begin
							kind_n = K_COUNT;
							last_n = 1'b1;
							bl_n   = BL_W'({bl_q[7:0], byte_q});
							if (bl_n == '0) begin
								finish = 1'b0;
								seq_n  = SEQ_POP;
							end else begin
								phase_n = PH_PAYLOAD;
							end
						end
						default: begin
							kind_n = K_PAYLOAD;
							bl_n   = bl_dec;
							if (bl_dec == '0) begin
								last_n = 1'b1;
								finish = 1'b0;
								seq_n  = SEQ_POP;
							end
						end
					endcase
				end
			end
			SEQ_POP: begin
				// one exhausted list closed per cycle
				if (sp_q != '0 && top.is_list && top.remaining == 32'd0) begin
					sp_n     = sp_q - SP_W'(1);
					closed_n = closed_q + 5'd1;
				end else if (sp_q == '0) begin
					status_n = ST_DONE;
					finish   = 1'b1;
				end else if (top.is_list) begin
					wr.en             = 1'b1;
					wr.data.remaining = top.remaining - 32'd1;
					seq_n             = SEQ_BEGIN;
				end else begin
					phase_n = PH_TAG_ID;
					finish  = 1'b1;
				end
			end
			SEQ_BEGIN: begin
				bv_go   = 1'b1;
				bv_type = top.elem_type;
				finish  = 1'b1;
			end
			default: begin
				seq_n = SEQ_IDLE;
			end
		endcase

		// start of a value of type bv_type
		if (bv_go) begin
			ctype_n = bv_type;
			case (bv_type)
				T_END: status_n = ST_END_LIST;
				T_BYTE: begin
					bl_n    = BL_W'(1);
					phase_n = PH_PAYLOAD;
				end
				T_SHORT: begin
					bl_n    = BL_W'(2);
					phase_n = PH_PAYLOAD;
				end
				T_INT, T_FLOAT: begin
					bl_n    = BL_W'(4);
					phase_n = PH_PAYLOAD;
				end
				T_LONG, T_DOUBLE: begin
					bl_n    = BL_W'(8);
					phase_n = PH_PAYLOAD;
				end
				T_BYTE_ARR, T_INT_ARR, T_LONG_ARR: begin
					bl_n    = BL_W'(4);
					ael_n   = 32'd0;
					phase_n = PH_COUNT;
				end
				T_STRING: phase_n = PH_STRLEN_HI;
				T_LIST, T_COMPOUND: begin
					if (sp_q >= SP_W'(MAX_DEPTH)) begin
						status_n = ST_OVERFLOW;
					end else begin
						wr.en             = 1'b1;
						wr.idx            = IDX_W'(sp_q);
						wr.data.is_list   = (bv_type == T_LIST);
						wr.data.elem_type = 4'd0;
						wr.data.remaining = 32'd0;
						sp_n              = sp_q + SP_W'(1);
						phase_n           = (bv_type == T_LIST) ? PH_LIST_TYPE : PH_TAG_ID;
					end
				end
				default: status_n = ST_BAD_ID;
			endcase
		end

		if (finish) begin
			seq_n = SEQ_IDLE;
		end
	end

	assign out_load = finish;
	assign out_data = {3'd0,
		(status_n == ST_DONE || status_n == ST_RUN) ? 3'd0 : 3'(status_n),
		(status_n == ST_DONE),
		closed_n,
		end_q ? 8'd0 : byte_q,
		5'(sp_n),
		ttype_n,
		3'(kind_n)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q    <= SEQ_IDLE;
			phase_q  <= PH_ROOT_ID;
			ctype_q  <= 4'd0;
			bl_q     <= '0;
			ael_q    <= 32'd0;
			sp_q     <= '0;
			status_q <= ST_RUN;
			m_tvalid <= 1'b0;
		end else begin
			seq_q    <= seq_n;
			phase_q  <= phase_n;
			ctype_q  <= ctype_n;
			bl_q     <= bl_n;
			ael_q    <= ael_n;
			sp_q     <= sp_n;
			status_q <= status_n;
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= s_tdata;
			end_q  <= s_tuser;
		end
		kind_q   <= kind_n;
		ttype_q  <= ttype_n;
		last_q   <= last_n;
		closed_q <= closed_n;
		if (out_load) begin
			m_tdata <= out_data;
			m_tlast <= last_n;
		end
	end

endmodule
`default_nettype wire

/* sv/nbt_tok_checker.sv */
// port-level checks for the tokenizer top level, bound into it
// depends on nbt_stream_tokenizer_unit ports only
`default_nettype none
module nbt_tok_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire        m_tlast
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// done and error never reported together
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[25] && m_tdata[28:26] != 3'd0))
		else $error("done with error");

	// ignored bytes close nothing and end no field
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == 3'd7 |-> m_tdata[24:20] == 5'd0 && !m_tlast)
		else $error("ignored byte with side effects");

	// depth never beyond the stack
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[11:7] <= 5'd16)
		else $error("depth out of range");

endmodule

bind nbt_stream_tokenizer_unit nbt_tok_checker u_nbt_tok_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* verif/tb.sv */
// testbench for nbt_stream_tokenizer_unit: one tag stream with random structure, checked
// transfer by transfer against a behavioral tokenizer kept in this module
// depends on nbt_tok_pkg and the tokenizer rtl
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import nbt_tok_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       eos;
	} in_item_t;

	typedef struct {
		logic [2:0] kind;
		logic [3:0] ttype;
		logic [4:0] depth;
		logic [7:0] value;
		logic       last;
		logic [4:0] closed;
		logic       done;
		logic [2:0] err;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	in_item_t pending_bytes[$];
	token_t   expected_tokens[$];
	int       errors = 0;
	int       cycles = 0;
	bit       running = 0;
	int       src_gap = 0;
	int       snk_gap = 0;

	// tokenizer state
	logic [3:0]  ph;
	logic [3:0]  cur_t;
	logic [34:0] left;
	logic [31:0] arr_left;
	frame_t      frames [MAX_DEPTH];
	int          sp;
	logic [2:0]  status;
	int          closed_now;

	always #5 clk = ~clk;

	nbt_stream_tokenizer_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	function void set_fail(logic [2:0] code);
		if (status == ST_RUN)
			status = code;
	endfunction

	function bit push_frame(logic is_list);
		if (sp >= MAX_DEPTH) begin
			set_fail(ST_OVERFLOW);
			return 0;
		end
		frames[sp].is_list = is_list;
		frames[sp].elem_type = '0;
		frames[sp].remaining = '0;
		sp++;
		return 1;
	endfunction

	function void begin_value(logic [3:0] t);
		cur_t = t;
		case (t)
			T_END: set_fail(ST_END_LIST);
			T_BYTE: begin left = 35'(1); ph = PH_PAYLOAD; end
			T_SHORT: begin left = 35'(2); ph = PH_PAYLOAD; end
			T_INT, T_FLOAT: begin left = 35'(4); ph = PH_PAYLOAD; end
			T_LONG, T_DOUBLE: begin left = 35'(8); ph = PH_PAYLOAD; end
			T_BYTE_ARR, T_INT_ARR, T_LONG_ARR: begin
				left = 35'(4);
				arr_left = '0;
				ph = PH_COUNT;
			end
			T_STRING: ph = PH_STRLEN_HI;
			T_LIST: if (push_frame(1'b1)) ph = PH_LIST_TYPE;
			T_COMPOUND: if (push_frame(1'b0)) ph = PH_TAG_ID;
			default: set_fail(ST_BAD_ID);
		endcase
	endfunction

	// pops every exhausted list, then ends the parse if the stack is empty, else starts the next list element or next tag
	function void complete_value();
		while (sp > 0 && frames[sp-1].is_list && frames[sp-1].remaining == 0) begin
			sp--;
			closed_now++;
		end
		if (sp == 0) begin
			status = ST_DONE;
			return;
		end
		if (frames[sp-1].is_list) begin
			frames[sp-1].remaining = frames[sp-1].remaining - 32'd1;
			begin_value(frames[sp-1].elem_type);
		end else
			ph = PH_TAG_ID;
	endfunction

	function token_t tokenize(logic [7:0] b, logic eos);
		token_t t;
		logic [31:0] n;
		logic [34:0] unit_sz;
		t.kind = K_IGNORED;
		t.ttype = '0;
		t.last = 1'b0;
		t.value = b;
		closed_now = 0;
		if (eos) begin
			t.value = '0;
			if (status == ST_RUN)
				status = ST_TRUNC;
		end else if (status == ST_RUN) begin
			t.ttype = cur_t;
			case (ph)
				PH_ROOT_ID: begin
					t.kind = K_TAG_ID;
					if (b == 8'(T_COMPOUND)) begin
						cur_t = T_COMPOUND;
						t.ttype = T_COMPOUND;
						ph = PH_NAME_HI;
					end else if (b > MAX_ID) begin
						t.ttype = '0;
						set_fail(ST_BAD_ID);
					end else begin
						t.ttype = b[3:0];
						set_fail(ST_ROOT);
					end
				end
				PH_TAG_ID: begin
					if (b > MAX_ID) begin
						t.kind = K_TAG_ID;
						t.ttype = '0;
						set_fail(ST_BAD_ID);
					end else if (b == 8'(T_END)) begin
						t.kind = K_END;
						t.ttype = '0;
						if (sp > 0)
							sp--;
						closed_now++;
						if (sp == 0)
							status = ST_DONE;
						else
							complete_value();
					end else begin
						t.kind = K_TAG_ID;
						t.ttype = b[3:0];
						cur_t = b[3:0];
						ph = PH_NAME_HI;
					end
				end
				PH_NAME_HI: begin
					t.kind = K_NAME_LEN;
					left = 35'(b);
					ph = PH_NAME_LO;
				end
				PH_NAME_LO: begin
					t.kind = K_NAME_LEN;
					t.last = 1'b1;
					left = 35'({left[7:0], b});
					if (left == 0)
						begin_value(cur_t);
					else
						ph = PH_NAME;
				end
				PH_NAME: begin
					t.kind = K_NAME;
					if (left > 0)
						left--;
					if (left == 0) begin
						t.last = 1'b1;
						begin_value(cur_t);
					end
				end
				PH_LIST_TYPE: begin
					t.kind = K_LIST_TYP;
					if (b > MAX_ID)
						set_fail(ST_BAD_ID);
					else begin
						if (sp > 0)
							frames[sp-1].elem_type = b[3:0];
						left = 35'(4);
						arr_left = '0;
						ph = PH_COUNT;
					end
				end
				PH_COUNT: begin
					t.kind = K_COUNT;
					arr_left = {arr_left[23:0], b};
					if (left > 0)
						left--;
					if (left == 0) begin
						t.last = 1'b1;
						// a count with the sign bit set is taken as zero
						n = arr_left[31] ? '0 : arr_left;
						if (cur_t == T_LIST) begin
							if (sp > 0)
								frames[sp-1].remaining = n;
							complete_value();
						end else begin
							unit_sz = (cur_t == T_BYTE_ARR) ? 35'(1) :
								(cur_t == T_INT_ARR) ? 35'(4) : 35'(8);
							left = 35'(n) * unit_sz;
							if (left == 0)
								complete_value();
							else
								ph = PH_PAYLOAD;
						end
					end
				end
				PH_STRLEN_HI: begin
					t.kind = K_COUNT;
					left = 35'(b);
					ph = PH_STRLEN_LO;
				end
				PH_STRLEN_LO: begin
					t.kind = K_COUNT;
					t.last = 1'b1;
					left = 35'({left[7:0], b});
					if (left == 0)
						complete_value();
					else
						ph = PH_PAYLOAD;
				end
				default: begin
					t.kind = K_PAYLOAD;
					if (left > 0)
						left--;
					if (left == 0) begin
						t.last = 1'b1;
						complete_value();
					end
				end
			endcase
		end
		t.depth = 5'(sp);
		t.closed = 5'(closed_now);
		t.done = (status == ST_DONE);
		t.err = (status >= ST_BAD_ID && status <= ST_TRUNC) ? status : ST_RUN;
		return t;
	endfunction

	// ---------------- stream builder ----------------
	function void put(logic [7:0] b);
		in_item_t it;
		it.b = b;
		it.eos = 1'b0;
		pending_bytes = {pending_bytes, it};
	endfunction

	function void put_rand(int n);
		for (int i = 0; i < n; i++)
			put(8'($urandom));
	endfunction

	function void put_name();
		int n;
		n = $urandom_range(0, 3);
		put(8'h00);
		put(8'(n));
		put_rand(n);
	endfunction

	function void put_count(int n);
		// now and then a negative count, read as zero
		if ($urandom_range(0, 19) == 0) begin
			put(8'h80 | 8'($urandom));
			put_rand(3);
		end else begin
			put(8'h00); put(8'h00); put(8'h00); put(8'(n));
		end
	endfunction

	function logic [3:0] pick_type(int lvl);
		logic [3:0] t;
		t = 4'($urandom_range(1, 12));
		// fewer containers as nesting grows, and none past the budget
		if ((t == T_LIST || t == T_COMPOUND) &&
				(lvl >= MAX_DEPTH - 1 || pending_bytes.size() > 850 ||
				 $urandom_range(0, lvl) > 2))
			t = 4'($urandom_range(1, 8));
		return t;
	endfunction

	function automatic void put_value(logic [3:0] t, int lvl);
		int n;
		logic [3:0] et;
		case (t)
			T_BYTE: put_rand(1);
			T_SHORT: put_rand(2);
			T_INT, T_FLOAT: put_rand(4);
			T_LONG, T_DOUBLE: put_rand(8);
			T_BYTE_ARR, T_INT_ARR, T_LONG_ARR: begin
				n = $urandom_range(0, 3);
				put_count(n);
				if (pending_bytes[$-3].b < 8'h80)
					put_rand(n * ((t == T_BYTE_ARR) ? 1 : (t == T_INT_ARR) ? 4 : 8));
			end
			T_STRING: begin
				n = $urandom_range(0, 4);
				put(8'h00); put(8'(n));
				put_rand(n);
			end
			T_LIST: begin
				et = pick_type(lvl + 1);
				n = $urandom_range(0, 3);
				if ($urandom_range(0, 9) == 0) begin
					et = T_END;
					n = 0;
				end
				put(8'(et));
				put_count(n);
				if (pending_bytes[$-3].b < 8'h80)
					for (int i = 0; i < n; i++)
						put_value(et, lvl + 1);
			end
			T_COMPOUND: begin
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					et = pick_type(lvl + 1);
					put(8'(et));
					put_name();
					put_value(et, lvl + 1);
				end
				put(8'(T_END));
			end
			default: ;
		endcase
	endfunction

	function void build_stream();
		in_item_t it;
		// opening: root, a list of lists whose close pops both, extreme bytes
		put(8'(T_COMPOUND)); put(8'h00); put(8'h01); put(8'hff);
		put(8'(T_LIST)); put(8'h00); put(8'h00);
		put(8'(T_LIST)); put(8'h00); put(8'h00); put(8'h00); put(8'h01);
		put(8'(T_BYTE)); put(8'h00); put(8'h00); put(8'h00); put(8'h01);
		put(8'h00);
		put(8'(T_BYTE)); put(8'h00); put(8'h00); put(8'hff);
		while (pending_bytes.size() < 860) begin
			logic [3:0] t;
			t = pick_type(1);
			put(8'(t));
			put_name();
			put_value(t, 1);
		end
		// one way to end the stream, chosen by the seed
		case ($urandom_range(0, 5))
			0, 1: put(8'(T_END));
			2: begin
				it.b = 8'($urandom);
				it.eos = 1'b1;
				pending_bytes = {pending_bytes, it};
			end
			3: put(8'($urandom_range(13, 255)));
			4: begin
				put(8'(T_LIST)); put_name(); put(8'(T_END));
				put(8'h00); put(8'h00); put(8'h00); put(8'($urandom_range(1, 255)));
			end
			default: begin
				// nest compounds until the stack is full, then one more
				for (int i = 0; i < MAX_DEPTH; i++) begin
					put(8'(T_COMPOUND));
					put_name();
				end
			end
		endcase
		// trailing items after the stream has stopped
		for (int i = 0; i < 20; i++) begin
			it.b = 8'($urandom);
			it.eos = 1'($urandom);
			pending_bytes = {pending_bytes, it};
		end
	endfunction

	// ---------------- driver ----------------
	always @(posedge clk) begin
		if (running) begin
			if (s_tvalid && s_tready)
				expected_tokens = {expected_tokens, tokenize(s_tdata, s_tuser)};
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 100 && $urandom_range(0, 9) == 0) begin
					src_gap <= $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_bytes[0].b;
					s_tuser <= pending_bytes[0].eos;
					void'(pending_bytes.pop_front());
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	function void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		token_t e;
		if (running) begin
			if (m_tvalid && m_tready) begin
				if (expected_tokens.size() == 0) begin
					$display("%0t: unexpected transfer, expected none, actual %h",
						$realtime, m_tdata);
					errors++;
				end else begin
					e = expected_tokens.pop_front();
					check_field("byte_kind", 8'(e.kind), 8'(m_tdata[2:0]));
					check_field("tag_type", 8'(e.ttype), 8'(m_tdata[6:3]));
					check_field("nest_depth", 8'(e.depth), 8'(m_tdata[11:7]));
					check_field("byte_value", e.value, m_tdata[19:12]);
					check_field("last_of_field", 8'(e.last), 8'(m_tlast));
					check_field("closed_count", 8'(e.closed), 8'(m_tdata[24:20]));
					check_field("parse_done", 8'(e.done), 8'(m_tdata[25]));
					check_field("error_code", 8'(e.err), 8'(m_tdata[28:26]));
					check_field("padding", 8'h00, 8'(m_tdata[31:29]));
				end
			end
			if (snk_gap > 0) begin
				snk_gap <= snk_gap - 1;
				m_tready <= 1'b0;
			end else if (pending_bytes.size() > 100 && $urandom_range(0, 9) == 0) begin
				snk_gap <= $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		ph = PH_ROOT_ID;
		cur_t = '0;
		left = '0;
		arr_left = '0;
		sp = 0;
		status = ST_RUN;
		build_stream();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running = 1;
		wait (pending_bytes.size() == 0 && !s_tvalid && expected_tokens.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_tokens.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
sv/nbt_tok_pkg.sv
sv/nbt_tok_stack.sv
sv/nbt_stream_tokenizer_unit.sv
sv/nbt_tok_checker.sv
verif/tb.sv
